### design/spd_pkg.sv
package spd_pkg;

   // Framing characters.
   localparam logic [7:0] SyncFirst  = 8'h4B;  // 'K'
   localparam logic [7:0] SyncSecond = 8'h53;  // 'S'
   localparam logic [7:0] Terminator = 8'h0D;  // carriage return

   // Bytes held back while hunting; the incoming byte completes the header.
   localparam int unsigned HistDepth = 6;

   // Fields decoded from a complete header.
   typedef struct packed {
      logic        hit;
      logic [3:0]  frame_type;
      logic [7:0]  param_first;
      logic [7:0]  param_second;
      logic [11:0] length;
   } header_type;

endpackage

### design/spd_header_match.sv
module spd_header_match (
   input  logic [7:0]        hist [spd_pkg::HistDepth],
   input  logic [7:0]        rx_byte,
   output spd_pkg::header_type header
);

   logic [7:0] check_sum;

   // Checksum covers the length low byte, the length/type byte and the two parameter bytes.
   assign check_sum = hist[2] + hist[3] + hist[4] + hist[5];

   // Sync pattern and checksum must both agree.
   always_comb begin
      header.hit          = (hist[0] == spd_pkg::SyncFirst) &&
                            (hist[1] == spd_pkg::SyncSecond) &&
                            (check_sum == rx_byte);
      header.frame_type   = hist[3][3:0];
      header.param_first  = hist[4];
      header.param_second = hist[5];
      header.length       = {hist[3][7:4], hist[2]};
   end

endmodule

### design/serial_packet_deframer_top.sv
// Serial packet deframer.
// Requests carry one received byte each on req_rx_byte (req_valid/req_ready).
// While hunting, the block watches for a seven-byte header: 'K', 'S', length
// low byte, length high nibble with type nibble, two parameter bytes and an
// 8-bit checksum of the middle four. Header bytes produce no response.
// Each following payload byte produces one response with rsp_result_kind 0,
// and the byte after the payload produces an end response (kind 1) whose
// rsp_frame_good reports the carriage-return check; csr_we/csr_wdata[0] turns
// that check off. After the end the block hunts again from an empty history.
// A response is registered and appears in the cycle after its request is
// accepted, and one request can be accepted every cycle.
// The single output register sets the rate: req_ready is low only while a
// response is held and rsp_ready is low, so a stalled receiver stalls the
// sender with no loss. Reset (synchronous) empties the output register,
// clears the history and enables the terminator check.
module serial_packet_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [3:0]  rsp_frame_type,
   output logic [7:0]  rsp_param_first,
   output logic [7:0]  rsp_param_second,
   output logic [11:0] rsp_payload_length,
   output logic        rsp_frame_good,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   localparam logic [1:0] PhHunt    = 2'd0;
   localparam logic [1:0] PhPayload = 2'd1;
   localparam logic [1:0] PhTerm    = 2'd2;

   logic              req_take;
   logic              req_term_ff;
   logic [1:0]        phase_ff, phase_in;
   logic [11:0]       left_ff, left_in;
   logic [7:0]        hist_ff [spd_pkg::HistDepth];
   logic [3:0]        type_ff;
   logic [7:0]        pfirst_ff, psecond_ff;
   logic [11:0]       len_ff;
   spd_pkg::header_type header;

   logic              rsp_valid_ff;
   logic              kind_ff, good_ff;
   logic [7:0]        data_ff;
   logic [3:0]        otype_ff;
   logic [7:0]        opfirst_ff, opsecond_ff;
   logic [11:0]       olen_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   spd_header_match u_match (
      .hist    (hist_ff),
      .rx_byte (req_rx_byte),
      .header  (header)
   );

   // Terminator check enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_term_ff <= 1'b1;
      end else if (csr_we) begin
         req_term_ff <= csr_wdata[0];
      end
   end

   // Next phase and remaining payload count.
   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      unique case (phase_ff)
         PhPayload: begin
            left_in = left_ff - 12'd1;
            if (left_ff == 12'd1) begin
               phase_in = PhTerm;
            end
         end
         PhTerm: begin
            phase_in = PhHunt;
            left_in  = '0;
         end
         default: begin
            phase_in = PhHunt;
            if (header.hit) begin
               left_in  = header.length;
               phase_in = (header.length == 12'd0) ? PhTerm : PhPayload;
            end
         end
      endcase
   end

   // Frame state, updated once per accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhHunt;
         left_ff    <= '0;
         type_ff    <= '0;
         pfirst_ff  <= '0;
         psecond_ff <= '0;
         len_ff     <= '0;
         for (int i = 0; i < spd_pkg::HistDepth; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (req_take) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         if (phase_ff == PhTerm) begin
            for (int i = 0; i < spd_pkg::HistDepth; i++) begin
               hist_ff[i] <= '0;
            end
         end else if (phase_ff != PhPayload) begin
            for (int i = 0; i < spd_pkg::HistDepth - 1; i++) begin
               hist_ff[i] <= hist_ff[i+1];
            end
            hist_ff[spd_pkg::HistDepth-1] <= req_rx_byte;
            if (header.hit) begin
               type_ff    <= header.frame_type;
               pfirst_ff  <= header.param_first;
               psecond_ff <= header.param_second;
               len_ff     <= header.length;
            end
         end
      end
   end

   // Response valid: set by payload and terminator requests, cleared when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= (phase_ff == PhPayload) || (phase_ff == PhTerm);
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff     <= (phase_ff == PhTerm);
         data_ff     <= (phase_ff == PhPayload) ? req_rx_byte : 8'd0;
         good_ff     <= (phase_ff == PhTerm) &&
                        (!req_term_ff || req_rx_byte == spd_pkg::Terminator);
         otype_ff    <= type_ff;
         opfirst_ff  <= pfirst_ff;
         opsecond_ff <= psecond_ff;
         olen_ff     <= len_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_data_byte      = data_ff;
   assign rsp_frame_type     = otype_ff;
   assign rsp_param_first    = opfirst_ff;
   assign rsp_param_second   = opsecond_ff;
   assign rsp_payload_length = olen_ff;
   assign rsp_frame_good     = good_ff;

endmodule
